### rtl/cpmd_pkg.sv
package cpmd_pkg;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_TOO_FEW  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_t;

endpackage

### rtl/cpmd_isqrt.sv
module cpmd_isqrt #(
  parameter int RAD_W = 49,
  localparam int ROOT_W = (RAD_W + 1) / 2
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAD_W-1:0]  radicand,
  output logic              done,
  output logic [ROOT_W-1:0] root
);
  import cpmd_pkg::*;

  localparam int PAD_W = 2 * ROOT_W;
  localparam int CNT_W = $clog2(ROOT_W + 1);

  logic [PAD_W-1:0]  rad_r;
  logic [ROOT_W:0]   rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [ROOT_W+2:0] rem_sh;
  logic [ROOT_W+2:0] trial;
  logic [ROOT_W+2:0] diff;
  logic              fits;

  assign rem_sh = {rem_r, rad_r[PAD_W-1 -: 2]};
  assign trial  = {1'b0, root_r, 2'b01};
  assign diff   = rem_sh - trial;
  assign fits   = (rem_sh >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rad_r  <= PAD_W'(radicand);
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rad_r <= {rad_r[PAD_W-3:0], 2'b00};
        if (fits) begin
          rem_r  <= diff[ROOT_W:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b1};
        end else begin
          rem_r  <= rem_sh[ROOT_W:0];
          root_r <= {root_r[ROOT_W-2:0], 1'b0};
        end
        if (cnt_r == CNT_W'(ROOT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  assign done = done_r;
  assign root = root_r;

endmodule

### rtl/closest_pair_min_distance_unit.sv
// Closest pair of points, brute force, one problem at a time.
// Input channel (in_valid / in_stall): one point per request, signed
// coordinates and last_point marking the final point of a problem.
// Result channel (out_valid / out_stall): one request per problem, issued
// after the point marked last: minimum squared distance, its floor square
// root and a status (ok, too few points, capacity exceeded).
// Each point is written to the point memory and then compared with the k
// points stored before it, one memory read per cycle through a four-stage
// read / difference / square / compare pipeline; the next point is taken
// only after the pipeline has drained. The last point then runs the
// two-bit-per-cycle square root (skipped with fewer than two points)
// before the result is loaded into the output register.
// Points beyond MAX_POINTS are dropped, not stored or compared, and flag overflow.
// in_stall is high whenever a point is in progress.
// A result waits in the output register while out_stall is high; the next
// point is taken meanwhile, and a new result waits until the old one leaves.
// Reset (rst_n low, synchronous) empties the problem; the point memory is not
// cleared, since only entries written in the current problem are read.
module closest_pair_min_distance_unit #(
  parameter int MAX_POINTS = 1024,
  parameter int COORD_BITS = 24
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [COORD_BITS-1:0] in_coord_x,
  input  logic signed [COORD_BITS-1:0] in_coord_y,
  input  logic                        in_last_point,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [2*COORD_BITS:0]       out_min_dist_sq,
  output logic [COORD_BITS:0]         out_min_dist,
  output cpmd_pkg::status_t           out_status
);
  import cpmd_pkg::*;

  localparam int C      = COORD_BITS;
  localparam int DSQ_W  = 2 * C + 1;
  localparam int DIST_W = C + 1;
  localparam int IDX_W  = $clog2(MAX_POINTS);
  localparam int CNT_W  = $clog2(MAX_POINTS + 1);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_SQRT, S_EMIT} state_t;

  state_t state_r;

  logic [2*C-1:0] mem [MAX_POINTS];
  logic [2*C-1:0] rd_data_r;
  logic           mem_we;
  logic [IDX_W-1:0] rd_addr;

  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] scan_n_r;
  logic [CNT_W-1:0] iss_r;
  logic [DSQ_W:0]   best_r;
  logic             ovf_r;
  logic             last_r;
  logic signed [C-1:0] x_r;
  logic signed [C-1:0] y_r;

  logic             v1_r, v2_r, v3_r;
  logic [C-1:0]     dx_r, dy_r;
  logic [2*C-1:0]   sqx_r, sqy_r;

  logic             accept;
  logic             issue;
  logic             drained;
  logic signed [C:0] diff_x, diff_y;
  logic [C:0]       adx, ady;
  logic [DSQ_W-1:0] d_sum;

  logic             sq_start;
  logic             sq_done;
  logic [DIST_W-1:0] sq_root;

  logic             out_valid_r;
  logic [DSQ_W-1:0] out_dsq_r;
  logic [DIST_W-1:0] out_dist_r;
  status_t          out_status_r;
  logic             out_free;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign mem_we   = accept && (count_r < CNT_W'(MAX_POINTS));
  assign issue    = (state_r == S_SCAN) && (iss_r < scan_n_r);
  assign rd_addr  = iss_r[IDX_W-1:0];
  assign drained  = !issue && !v1_r && !v2_r && !v3_r;
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[count_r[IDX_W-1:0]] <= {in_coord_x, in_coord_y};
    end
    rd_data_r <= mem[rd_addr];
  end

  assign diff_x = {x_r[C-1], x_r} - {rd_data_r[2*C-1], rd_data_r[2*C-1:C]};
  assign diff_y = {y_r[C-1], y_r} - {rd_data_r[C-1], rd_data_r[C-1:0]};
  assign adx    = diff_x[C] ? (C+1)'(-diff_x) : (C+1)'(diff_x);
  assign ady    = diff_y[C] ? (C+1)'(-diff_y) : (C+1)'(diff_y);
  assign d_sum  = {1'b0, sqx_r} + {1'b0, sqy_r};

  always_ff @(posedge clk) begin
    dx_r  <= adx[C-1:0];
    dy_r  <= ady[C-1:0];
    sqx_r <= dx_r * dx_r;
    sqy_r <= dy_r * dy_r;
  end

  assign sq_start = (state_r == S_SCAN) && drained && last_r &&
                    (count_r >= CNT_W'(2));

  cpmd_isqrt #(.RAD_W(DSQ_W)) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sq_start),
    .radicand (best_r[DSQ_W-1:0]),
    .done     (sq_done),
    .root     (sq_root)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      scan_n_r    <= '0;
      iss_r       <= '0;
      best_r      <= '1;
      ovf_r       <= 1'b0;
      last_r      <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      if (issue) begin
        iss_r <= iss_r + 1'b1;
      end
      if (v3_r && ({1'b0, d_sum} < best_r)) begin
        best_r <= {1'b0, d_sum};
      end
      if (out_valid_r && !out_stall && (state_r != S_EMIT)) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            x_r    <= in_coord_x;
            y_r    <= in_coord_y;
            last_r <= in_last_point;
            iss_r  <= '0;
            if (mem_we) begin
              scan_n_r <= count_r;
              count_r  <= count_r + 1'b1;
            end else begin
              scan_n_r <= '0;
              ovf_r    <= 1'b1;
            end
            state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (drained) begin
            priority if (!last_r) begin
              state_r <= S_IDLE;
            end else if (sq_start) begin
              state_r <= S_SQRT;
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_SQRT: begin
          if (sq_done) begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            if (count_r < CNT_W'(2)) begin
              out_dsq_r    <= '0;
              out_dist_r   <= '0;
              out_status_r <= ST_TOO_FEW;
            end else begin
              out_dsq_r    <= best_r[DSQ_W-1:0];
              out_dist_r   <= sq_root;
              out_status_r <= ovf_r ? ST_OVERFLOW : ST_OK;
            end
            count_r <= '0;
            best_r  <= '1;
            ovf_r   <= 1'b0;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_min_dist_sq = out_dsq_r;
  assign out_min_dist    = out_dist_r;
  assign out_status      = out_status_r;

endmodule

### rtl/cpmd_checker.sv
module cpmd_checker #(
  parameter int COORD_BITS = 24
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_stall,
  input logic                         out_valid,
  input logic                         out_stall,
  input logic [2*COORD_BITS:0]        out_min_dist_sq,
  input logic [COORD_BITS:0]          out_min_dist,
  input cpmd_pkg::status_t            out_status
);
  import cpmd_pkg::*;

  localparam int DIST_W = COORD_BITS + 1;

  logic [2*DIST_W+1:0] lo_sq;
  logic [2*DIST_W+1:0] hi_sq;

  assign lo_sq = out_min_dist * out_min_dist;
  assign hi_sq = (out_min_dist + 1'b1) * (out_min_dist + 1'b1);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_min_dist_sq) &&
      $stable(out_min_dist) && $stable(out_status))
    else $error("result changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("point request not followed by busy cycle");

  a_too_few_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_TOO_FEW |-> out_min_dist_sq == '0 &&
      out_min_dist == '0)
    else $error("too-few result carries nonzero distance");

  a_root_floor: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_OK || out_status == ST_OVERFLOW) |->
      lo_sq <= (2*DIST_W+2)'(out_min_dist_sq) &&
      hi_sq > (2*DIST_W+2)'(out_min_dist_sq))
    else $error("distance is not floor square root");

endmodule

bind closest_pair_min_distance_unit cpmd_checker #(.COORD_BITS(COORD_BITS)) u_cpmd_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_stall        (in_stall),
  .out_valid       (out_valid),
  .out_stall       (out_stall),
  .out_min_dist_sq (out_min_dist_sq),
  .out_min_dist    (out_min_dist),
  .out_status      (out_status)
);
